// ===== sv/clt_pkg.sv =====
`default_nettype none

package clt_pkg;

   // Default width of the argument counter
   localparam int COUNT_BITS_DEF = 8;

   // Results that one input beat can cause at most
   localparam int MAX_RESULTS = 4;
   localparam int SLOT_BITS   = $clog2(MAX_RESULTS);
   localparam int NUM_BITS    = $clog2(MAX_RESULTS + 1);

   // Result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_ARG_END = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   // Characters with a meaning of their own
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_ESCAPE = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_E_LO   = 8'h65;
   localparam logic [7:0] CH_E_UP   = 8'h45;
   localparam logic [7:0] CH_N_LO   = 8'h6E;
   localparam logic [7:0] CH_N_UP   = 8'h4E;

   // Scanner state
   typedef enum logic [4:0] {
      MODE_BETWEEN = 5'b00001,
      MODE_PLAIN   = 5'b00010,
      MODE_QUOTED  = 5'b00100,
      MODE_ESCAPE  = 5'b01000,
      MODE_HELD    = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] arg_number;
      logic       last;
   } rsp_type;

   // One decoded result before it is sent
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
   } slot_type;

   // All results of one input beat
   typedef struct packed {
      slot_type [MAX_RESULTS-1:0] slots;
      logic [NUM_BITS-1:0]        num;
      logic [7:0]                 arg_number;
   } dec_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

endpackage

`default_nettype wire

// ===== sv/clt_decode.sv =====
`default_nettype none

module clt_decode #(
   parameter int COUNT_BITS = clt_pkg::COUNT_BITS_DEF
) (
   input  wire clt_pkg::req_type  req_in,
   input  wire clt_pkg::mode_type mode,
   input  wire [COUNT_BITS-1:0]   count,
   input  wire                    closed,
   output clt_pkg::mode_type      mode_in,
   output logic [COUNT_BITS-1:0]  count_in,
   output logic                   closed_in,
   output clt_pkg::dec_type       dec
);

   localparam int EXT_BITS = COUNT_BITS + 8;

   // Work out every result of one beat and the next scanner state
   always_comb begin
      logic [clt_pkg::NUM_BITS-1:0] n;
      logic [7:0]                   c;
      logic                         fin;
      logic [EXT_BITS-1:0]          count_ext;
      n         = '0;
      c         = req_in.in_byte;
      fin       = 1'b0;
      mode_in   = mode;
      count_in  = count;
      closed_in = closed;
      dec.slots = '0;
      if (!closed) begin
         if (c == clt_pkg::CH_NUL) begin
            fin = 1'b1;
         end else begin
            fin = req_in.end_of_string;
            case (mode)
               clt_pkg::MODE_PLAIN: begin
                  if (clt_pkg::is_blank(c)) begin
                     dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_ARG_END, 8'h00};
                     n = n + 1'b1;
                     mode_in = clt_pkg::MODE_BETWEEN;
                  end else begin
                     dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_BYTE, c};
                     n = n + 1'b1;
                  end
               end
               clt_pkg::MODE_QUOTED: begin
                  if (c == clt_pkg::CH_ESCAPE) begin
                     mode_in = clt_pkg::MODE_ESCAPE;
                  end else if (c == clt_pkg::CH_QUOTE) begin
                     mode_in = clt_pkg::MODE_HELD;
                  end else begin
                     dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_BYTE, c};
                     n = n + 1'b1;
                  end
               end
               clt_pkg::MODE_ESCAPE: begin
                  if (c == clt_pkg::CH_E_LO || c == clt_pkg::CH_E_UP) begin
                     dec.slots[n[clt_pkg::SLOT_BITS-1:0]] =
                        {clt_pkg::KIND_BYTE, clt_pkg::CH_ESC};
                  end else if (c == clt_pkg::CH_N_LO || c == clt_pkg::CH_N_UP) begin
                     dec.slots[n[clt_pkg::SLOT_BITS-1:0]] =
                        {clt_pkg::KIND_BYTE, clt_pkg::CH_NL};
                  end else begin
                     dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_BYTE, c};
                  end
                  n = n + 1'b1;
                  mode_in = clt_pkg::MODE_QUOTED;
               end
               clt_pkg::MODE_HELD: begin
                  if (clt_pkg::is_blank(c)) begin
                     dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_ARG_END, 8'h00};
                     n = n + 1'b1;
                     mode_in = clt_pkg::MODE_BETWEEN;
                  end else begin
                     // Release the held quote as a literal, then treat c as quoted
                     dec.slots[n[clt_pkg::SLOT_BITS-1:0]] =
                        {clt_pkg::KIND_BYTE, clt_pkg::CH_QUOTE};
                     n = n + 1'b1;
                     mode_in = clt_pkg::MODE_QUOTED;
                     if (c == clt_pkg::CH_ESCAPE) begin
                        mode_in = clt_pkg::MODE_ESCAPE;
                     end else if (c == clt_pkg::CH_QUOTE) begin
                        mode_in = clt_pkg::MODE_HELD;
                     end else begin
                        dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_BYTE, c};
                        n = n + 1'b1;
                     end
                  end
               end
               default: begin
                  // Between arguments: a non-blank byte opens a new argument
                  if (!clt_pkg::is_blank(c)) begin
                     if (count != {COUNT_BITS{1'b1}}) begin
                        count_in = count + 1'b1;
                     end
                     if (c == clt_pkg::CH_QUOTE) begin
                        mode_in = clt_pkg::MODE_QUOTED;
                     end else begin
                        mode_in = clt_pkg::MODE_PLAIN;
                        dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_BYTE, c};
                        n = n + 1'b1;
                     end
                  end else begin
                     mode_in = clt_pkg::MODE_BETWEEN;
                  end
               end
            endcase
         end
         // Close the string: end an open argument, then report the count
         if (fin) begin
            if (mode_in != clt_pkg::MODE_BETWEEN) begin
               dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_ARG_END, 8'h00};
               n = n + 1'b1;
            end
            dec.slots[n[clt_pkg::SLOT_BITS-1:0]] = {clt_pkg::KIND_DONE, 8'h00};
            n = n + 1'b1;
            mode_in   = clt_pkg::MODE_BETWEEN;
            closed_in = 1'b1;
         end
      end
      dec.num = n;
      // Saturate the reported argument number at eight bits
      count_ext      = {8'h00, count_in};
      dec.arg_number = (count_ext > EXT_BITS'(255)) ? 8'hFF : count_ext[7:0];
   end

endmodule

`default_nettype wire

// ===== sv/clt_buffer.sv =====
`default_nettype none

module clt_buffer (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  wire clt_pkg::dec_type  dec,
   output logic                   free,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output clt_pkg::rsp_type       rsp_data
);

   clt_pkg::slot_type [clt_pkg::MAX_RESULTS-1:0] slots_ff;
   logic [7:0]                                   arg_ff;
   logic [clt_pkg::NUM_BITS-1:0]                 remain_ff;
   logic [clt_pkg::NUM_BITS-1:0]                 remain_in;
   logic [clt_pkg::SLOT_BITS-1:0]                idx_ff;
   logic [clt_pkg::SLOT_BITS-1:0]                idx_in;
   logic                                         sent;

   assign rsp_valid = (remain_ff != '0);
   assign sent      = rsp_valid && rsp_ready;
   // Free when empty or when the final beat leaves this cycle
   assign free      = !rsp_valid || (sent && (remain_ff == clt_pkg::NUM_BITS'(1)));

   // Present the current slot
   assign rsp_data.kind       = slots_ff[idx_ff].kind;
   assign rsp_data.out_byte   = slots_ff[idx_ff].out_byte;
   assign rsp_data.arg_number = arg_ff;
   assign rsp_data.last       = (remain_ff == clt_pkg::NUM_BITS'(1));

   // Load a fresh group or advance through the current one
   always_comb begin
      remain_in = remain_ff;
      idx_in    = idx_ff;
      if (load) begin
         remain_in = dec.num;
         idx_in    = '0;
      end else if (sent) begin
         remain_in = remain_ff - 1'b1;
         idx_in    = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         idx_ff    <= '0;
      end else begin
         remain_ff <= remain_in;
         idx_ff    <= idx_in;
      end
   end

   // Hold the payload of the group
   always_ff @(posedge clock) begin
      if (load) begin
         slots_ff <= dec.slots;
         arg_ff   <= dec.arg_number;
      end
   end

   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= clt_pkg::NUM_BITS'(clt_pkg::MAX_RESULTS))
      else $error("result count out of range");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (sent && !load) |=> (remain_ff == $past(remain_ff) - 1'b1))
      else $error("sent beat did not advance the group");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("group loaded over pending results");

endmodule

`default_nettype wire

// ===== sv/command_line_tokenizer.sv =====
// Command-line tokenizer: splits a string, one byte per req beat, into
// arguments on the rsp channel.
//  - req_data carries one character and an end_of_string flag; a zero
//    character also ends the string.
//  - Each req beat gives zero to four rsp beats: argument bytes (quotes and
//    '*' escapes resolved), argument-end marks, and after the end of the
//    string one beat with the argument count (program slot counts as one).
//    rsp_data.last marks the final beat caused by a req beat.
//  - A req beat is registered, decoded from the input register and its
//    results are loaded into a result buffer once that is free; rsp_valid
//    is raised by the result buffer while it holds results.
//  - Throughput is one rsp beat per cycle while rsp_ready is high, set by the
//    result buffer, which sends one slot per cycle; beats that give one or no
//    result stream at one req beat per cycle, a beat with more results holds the input until its last result is sent.
//  - If rsp_ready is low, the result buffer holds its beat, the input
//    register fills and req_ready drops; nothing is lost.
//  - Reset clears the scanner (between arguments, count one) and empties
//    both stages. After the string ends, further bytes are taken and dropped
//    until the next reset.
`default_nettype none

module command_line_tokenizer #(
   parameter int COUNT_BITS = clt_pkg::COUNT_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire clt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output clt_pkg::rsp_type      rsp_data
);

   logic                  req_valid_ff;
   clt_pkg::req_type      req_data_ff;
   clt_pkg::mode_type     mode_ff;
   clt_pkg::mode_type     mode_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  closed_ff;
   logic                  closed_in;
   clt_pkg::dec_type      dec;
   logic                  buf_free;
   logic                  move;

   // Hand the registered beat on when the result buffer frees up
   assign move      = req_valid_ff && buf_free;
   assign req_ready = !req_valid_ff || move;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_data_ff <= req_data;
      end
   end

   // Scanner state advances once per decoded beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= clt_pkg::MODE_BETWEEN;
         count_ff  <= COUNT_BITS'(1);
         closed_ff <= 1'b0;
      end else if (move) begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         closed_ff <= closed_in;
      end
   end

   clt_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .req_in    (req_data_ff),
      .mode      (mode_ff),
      .count     (count_ff),
      .closed    (closed_ff),
      .mode_in   (mode_in),
      .count_in  (count_in),
      .closed_in (closed_in),
      .dec       (dec)
   );

   clt_buffer u_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (move),
      .dec       (dec),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed string reopened without reset");

   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      (move && closed_ff) |-> (dec.num == '0))
      else $error("results produced after the string ended");

   a_finish_mode: assert property (@(posedge clock) disable iff (reset)
      (move && closed_in && !closed_ff) |=> (mode_ff == clt_pkg::MODE_BETWEEN))
      else $error("scanner not back between arguments after the end");

endmodule

`default_nettype wire
